// ----- design/vtr_pkg.sv -----
// Shared types and constants for the texel to RGB888 converter.
// No dependencies; imported by every module of the block.
package vtr_pkg;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int FMT_W      = 3;
    localparam int SUM_W      = 20;

    localparam logic [0:0] REG_SOURCE_FORMAT = 1'd0;

    localparam logic [FMT_W-1:0] FMT_YUYV     = 3'd0;
    localparam logic [FMT_W-1:0] FMT_UYVY     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_AYUV     = 3'd2;
    localparam logic [FMT_W-1:0] FMT_Y8       = 3'd3;
    localparam logic [FMT_W-1:0] FMT_ARGB8888 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd5;
    localparam logic [FMT_W-1:0] FMT_ARGB1555 = 3'd6;

    typedef struct packed {
        logic       is_yuv;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_texel;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    function automatic logic [7:0] clamp_u8(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum < 0) begin
            res = 8'd0;
        end else if (sum > 20'sd65535) begin
            res = 8'd255;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

endpackage

// ----- design/video_texel_to_rgb888.sv -----
// Texel to RGB888 converter: input register, format unpack and matrix, result register.
// An input transfer enters the input register, then the result register, which drives o_valid.
// Throughput is one texel per cycle while i_stall does not hold the output back.
// Depends on vtr_pkg, vtr_unpack and vtr_matrix.
// Reset (synchronous, active low) empties both stages and sets source_format to YUYV.
module video_texel_to_rgb888
    import vtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_texel_bytes,
    input  logic                  i_odd_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);

    logic [FMT_W-1:0] r_format;
    logic             r_s1_valid, n_s1_valid;
    logic [31:0]      r_s1_bytes;
    logic             r_s1_odd;
    logic             r_s2_valid, n_s2_valid;
    t_rgb             r_s2_rgb;
    logic             cfg_wr, reg_hit, s2_free, in_xfer, s1_move;
    t_texel           texel;
    t_rgb             rgb;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_SOURCE_FORMAT);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? {{(APB_DATA_W-FMT_W){1'b0}}, r_format} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_YUYV;
        end else if (cfg_wr) begin
            r_format <= pwdata[FMT_W-1:0];
        end
    end

    assign s2_free    = !r_s2_valid || !i_stall;
    assign o_stall    = r_s1_valid && !s2_free;
    assign in_xfer    = i_valid && !o_stall;
    assign s1_move    = r_s1_valid && s2_free;
    assign n_s1_valid = in_xfer || (r_s1_valid && !s2_free);
    assign n_s2_valid = s1_move || (r_s2_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_bytes <= i_texel_bytes;
            r_s1_odd   <= i_odd_pixel;
        end
        if (s1_move) begin
            r_s2_rgb <= rgb;
        end
    end

    vtr_unpack u_unpack (
        .i_format      (r_format),
        .i_texel_bytes (r_s1_bytes),
        .i_odd_pixel   (r_s1_odd),
        .o_texel       (texel)
    );

    vtr_matrix u_matrix (
        .i_texel (texel),
        .o_rgb   (rgb)
    );

    assign o_valid = r_s2_valid;
    assign o_red   = r_s2_rgb.r;
    assign o_green = r_s2_rgb.g;
    assign o_blue  = r_s2_rgb.b;

endmodule

// ----- design/vtr_unpack.sv -----
// Byte selection for each source format: luma/chroma or repacked RGB.
// Depends on vtr_pkg.
module vtr_unpack
    import vtr_pkg::*;
(
    input  logic [FMT_W-1:0] i_format,
    input  logic [31:0]      i_texel_bytes,
    input  logic             i_odd_pixel,
    output t_texel           o_texel
);

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] px;

    assign b0 = i_texel_bytes[7:0];
    assign b1 = i_texel_bytes[15:8];
    assign b2 = i_texel_bytes[23:16];
    assign b3 = i_texel_bytes[31:24];
    assign px = {b0, b1};

    always_comb begin
        o_texel = '{is_yuv: 1'b0, y: 8'd0, u: 8'd128, v: 8'd128,
                    r: 8'd0, g: 8'd0, b: 8'd0};
        case (i_format)
            FMT_YUYV: begin
                o_texel.is_yuv = 1'b1;
                o_texel.y      = i_odd_pixel ? b2 : b0;
                o_texel.u      = b1;
                o_texel.v      = b3;
            end
            FMT_UYVY: begin
                o_texel.is_yuv = 1'b1;
                o_texel.y      = i_odd_pixel ? b3 : b1;
                o_texel.u      = b0;
                o_texel.v      = b2;
            end
            FMT_AYUV: begin
                o_texel.is_yuv = 1'b1;
                o_texel.y      = b1;
                o_texel.u      = b2;
                o_texel.v      = b3;
            end
            FMT_Y8: begin
                o_texel.is_yuv = 1'b1;
                o_texel.y      = b0;
            end
            FMT_ARGB8888: begin
                o_texel.r = b1;
                o_texel.g = b2;
                o_texel.b = b3;
            end
            FMT_RGB565: begin
                o_texel.r = {px[15:11], 3'b000};
                o_texel.g = {px[10:5], 2'b00};
                o_texel.b = {px[4:0], 3'b000};
            end
            FMT_ARGB1555: begin
                o_texel.r = {px[14:10], 3'b000};
                o_texel.g = {px[9:5], 3'b000};
                o_texel.b = {px[4:0], 3'b000};
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/vtr_matrix.sv -----
// Integer BT.601 YUV to RGB matrix with rounding and clamping.
// Passes repacked RGB through for non-YUV formats. Depends on vtr_pkg.
module vtr_matrix
    import vtr_pkg::*;
(
    input  t_texel i_texel,
    output t_rgb   o_rgb
);

    logic signed [SUM_W-1:0] c, d, e;
    logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

    always_comb begin
        c = ($signed({12'd0, i_texel.y}) - 20'sd16) * 20'sd298;
        d = $signed({12'd0, i_texel.u}) - 20'sd128;
        e = $signed({12'd0, i_texel.v}) - 20'sd128;
        sum_r = c + 20'sd409 * e + 20'sd128;
        sum_g = c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
        sum_b = c + 20'sd516 * d + 20'sd128;
        if (i_texel.is_yuv) begin
            o_rgb.r = clamp_u8(sum_r);
            o_rgb.g = clamp_u8(sum_g);
            o_rgb.b = clamp_u8(sum_b);
        end else begin
            o_rgb.r = i_texel.r;
            o_rgb.g = i_texel.g;
            o_rgb.b = i_texel.b;
        end
    end

endmodule

// ----- design/vtr_checker.sv -----
// Port-level checks for video_texel_to_rgb888, attached by bind.
// Depends on vtr_pkg.
module vtr_checker
    import vtr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output could drain");

    a_transfer_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("transfer did not reach output");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green)
                                  && $stable(o_blue)))
        else $error("stalled result changed");

endmodule

bind video_texel_to_rgb888 vtr_checker u_vtr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);
